// ----- rtl/wscd_pkg.sv -----
// Shared constants and codes for the window / slope / change detector.
package wscd_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int WORD_WIDTH   = 32;
  localparam int CFG_WIDTH    = (SAMPLE_WIDTH > WORD_WIDTH) ? SAMPLE_WIDTH : WORD_WIDTH;
  localparam int DELTA_WIDTH  = SAMPLE_WIDTH + 1;
  localparam int CMP_WIDTH    = SAMPLE_WIDTH + 2;
  localparam int REG_IDX_W    = 3;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_CONTROL_KIND    = 3'd0;
  localparam reg_idx_t REG_COMPARE_MODE    = 3'd1;
  localparam reg_idx_t REG_ABSOLUTE_DELTA  = 3'd2;
  localparam reg_idx_t REG_LOWER_LIMIT     = 3'd3;
  localparam reg_idx_t REG_UPPER_LIMIT     = 3'd4;
  localparam reg_idx_t REG_REFERENCE_LEVEL = 3'd5;
  localparam reg_idx_t REG_VALUE_ON_TRUE   = 3'd6;
  localparam reg_idx_t REG_VALUE_ON_FALSE  = 3'd7;

  typedef logic [1:0] code_t;

  localparam code_t KIND_WINDOW = 2'd0;
  localparam code_t KIND_SLOPE  = 2'd1;
  localparam code_t KIND_CHANGE = 2'd2;

  localparam code_t WIN_INSIDE   = 2'd0;
  localparam code_t SLOPE_RISING = 2'd0;
  localparam code_t CHG_GT       = 2'd0;
  localparam code_t CHG_GE       = 2'd1;
  localparam code_t CHG_LT       = 2'd2;
  localparam code_t CHG_LE       = 2'd3;

endpackage

// ----- rtl/window_slope_change_detector.sv -----
// Window / level-crossing / change detector, top level.
//
//   channel  direction  handshake           payload
//   in       to block   in_valid, in_stall  sample
//   out      from block out_valid, out_stall out_word, condition_met
//   cfg      to block   cfg_write           cfg_index, cfg_data
//
// A request accepted into the input register passes through one
// compare/subtract stage into the result register. One request per cycle
// sustained while out_stall is low; in slope and change modes the single
// previous-sample register is updated as the result register loads.
// rst (synchronous) resets the handshake state, previous sample and config.
// in_stall rises only when both stages hold requests and out_stall is high.
module window_slope_change_detector
  import wscd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [WORD_WIDTH-1:0]   out_word,
  output logic                          condition_met,
  input  logic                          cfg_write,
  input  reg_idx_t                      cfg_index,
  input  logic [CFG_WIDTH-1:0]          cfg_data
);

  code_t                          control_kind;
  code_t                          compare_mode;
  logic                           absolute_delta;
  logic signed [SAMPLE_WIDTH-1:0] lower_limit;
  logic signed [SAMPLE_WIDTH-1:0] upper_limit;
  logic signed [SAMPLE_WIDTH-1:0] reference_level;
  logic signed [WORD_WIDTH-1:0]   value_on_true;
  logic signed [WORD_WIDTH-1:0]   value_on_false;
  logic signed [SAMPLE_WIDTH-1:0] prev_sample;

  logic                           s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample;
  logic                           s1_adv;
  logic                           in_accept;

  logic                           hit;
  logic                           keep_sample;
  logic signed [DELTA_WIDTH-1:0]  delta;
  logic [DELTA_WIDTH-1:0]         delta_mag;
  logic signed [DELTA_WIDTH-1:0]  lim_ext;
  logic [DELTA_WIDTH-1:0]         lim_mag;
  logic signed [CMP_WIDTH-1:0]    delta_cmp;
  logic signed [CMP_WIDTH-1:0]    lim_cmp;

  // Config register file
  always_ff @(posedge clk) begin
    if (rst) begin
      control_kind    <= KIND_WINDOW;
      compare_mode    <= WIN_INSIDE;
      absolute_delta  <= 1'b0;
      lower_limit     <= '0;
      upper_limit     <= '0;
      reference_level <= '0;
      value_on_true   <= WORD_WIDTH'(1);
      value_on_false  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CONTROL_KIND:    control_kind    <= cfg_data[1:0];
        REG_COMPARE_MODE:    compare_mode    <= cfg_data[1:0];
        REG_ABSOLUTE_DELTA:  absolute_delta  <= cfg_data[0];
        REG_LOWER_LIMIT:     lower_limit     <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_UPPER_LIMIT:     upper_limit     <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_REFERENCE_LEVEL: reference_level <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_VALUE_ON_TRUE:   value_on_true   <= cfg_data[WORD_WIDTH-1:0];
        REG_VALUE_ON_FALSE:  value_on_false  <= cfg_data[WORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample <= sample;
    end
  end

  // Delta formed one bit wider so it cannot wrap; magnitudes compared with a zero sign bit.
  always_comb begin
    delta     = DELTA_WIDTH'({s1_sample[SAMPLE_WIDTH-1], s1_sample})
              - DELTA_WIDTH'({prev_sample[SAMPLE_WIDTH-1], prev_sample});
    delta_mag = delta[DELTA_WIDTH-1] ? (~delta + 1'b1) : delta;
    lim_ext   = {reference_level[SAMPLE_WIDTH-1], reference_level};
    lim_mag   = lim_ext[DELTA_WIDTH-1] ? (~lim_ext + 1'b1) : lim_ext;
    if (absolute_delta) begin
      delta_cmp = {1'b0, delta_mag};
      lim_cmp   = {1'b0, lim_mag};
    end else begin
      delta_cmp = {delta[DELTA_WIDTH-1], delta};
      lim_cmp   = {lim_ext[DELTA_WIDTH-1], lim_ext};
    end
  end

  always_comb begin
    hit         = 1'b0;
    keep_sample = 1'b0;
    unique case (control_kind)
      KIND_WINDOW: begin
        if (compare_mode == WIN_INSIDE) begin
          hit = (s1_sample >= lower_limit) && (s1_sample < upper_limit);
        end else begin
          hit = (s1_sample <= lower_limit) || (s1_sample > upper_limit);
        end
      end
      KIND_SLOPE: begin
        keep_sample = 1'b1;
        if (compare_mode == SLOPE_RISING) begin
          hit = (prev_sample <= reference_level) && (s1_sample > reference_level);
        end else begin
          hit = (prev_sample > reference_level) && (s1_sample <= reference_level);
        end
      end
      KIND_CHANGE: begin
        keep_sample = 1'b1;
        unique case (compare_mode)
          CHG_GT:  hit = delta_cmp > lim_cmp;
          CHG_GE:  hit = delta_cmp >= lim_cmp;
          CHG_LT:  hit = delta_cmp < lim_cmp;
          CHG_LE:  hit = delta_cmp <= lim_cmp;
          default: hit = 1'b0;
        endcase
      end
      default: begin
        hit         = 1'b0;
        keep_sample = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
    end else if (s1_adv && keep_sample) begin
      prev_sample <= s1_sample;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_word      <= hit ? value_on_true : value_on_false;
      condition_met <= hit;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled without a held request");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_sample))
    else $error("held request lost or changed");

  a_prev_moves_on_advance: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(prev_sample) |-> $past(s1_adv))
    else $error("previous sample changed without a request");

  a_result_from_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_adv))
    else $error("result appeared without a request");
`endif

endmodule
